// ===== hw/rtl/tlnt_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, command codes and result codes of the two-level name table.
// Used by the top level and the testbench; depends on nothing.
package tlnt_pkg;

  localparam int MAX_DIRS      = 8;
  localparam int FILES_PER_DIR = 8;
  localparam int NAME_BITS     = 128;

  localparam int KEY_W    = 128;
  localparam int HALF_W   = 64;
  localparam int PAD_BITS = KEY_W - NAME_BITS;

  localparam int DIR_AW  = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int DIR_CW  = $clog2(MAX_DIRS + 1);
  localparam int FILE_AW = (FILES_PER_DIR > 1) ? $clog2(FILES_PER_DIR) : 1;
  localparam int FILE_CW = $clog2(FILES_PER_DIR + 1);
  localparam int FRAM_AW = DIR_AW + FILE_AW;
  localparam int FRAM_DEPTH = MAX_DIRS * (1 << FILE_AW);

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 4;

  localparam logic [MODE_W-1:0] MODE_MKDIR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MKFILE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DIR_MADE       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DIR_EXISTS     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_DIR_TABLE_FULL = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FILE_MADE      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FILE_EXISTS    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NO_DIR         = 4'd5;
  localparam logic [STATUS_W-1:0] ST_DELETED        = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FOUND          = 4'd8;
  localparam logic [STATUS_W-1:0] ST_DIR_FULL       = 4'd9;
  localparam logic [STATUS_W-1:0] ST_LIST_ENTRY     = 4'd10;
  localparam logic [STATUS_W-1:0] ST_DIR_EMPTY      = 4'd11;

endpackage

// ===== hw/rtl/tlnt_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; holds the directory keys and the file keys of the name table.
module tlnt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/two_level_name_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the two-level name table: command sequencer, counts and output word.
// Depends on tlnt_pkg and two tlnt_ram instances (directory keys, file keys).
//
// Usage: one input word carries a command (mode), a directory key and a file key.
// The block takes a word when in_valid is high and in_stall is low, and holds
// in_stall high until the last result word of that command has been loaded into
// the output register. Each command gives one result word, except a listing,
// which gives one word per file with out_last set on the final one.
// Only the top NAME_BITS bits of each key count; the rest read as zero.
// Search: the sequencer walks the directory table and then the found directory's
// file slots, with one key comparator for directories and one for files. Each
// entry is read in one state and compared in the next; a delete then moves the
// last file of the directory into the freed slot.
// Results wait in the output register while out_stall is high; the sequencer
// pauses until that register is free, and no word is lost or repeated.
// Reset clears the directory count, all file counts and the output valid flag;
// no clearing pass is needed and the block is ready right after reset.
module two_level_name_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlnt_pkg::MODE_W-1:0]   in_mode,
  input  logic [tlnt_pkg::HALF_W-1:0]   in_dir_key_hi,
  input  logic [tlnt_pkg::HALF_W-1:0]   in_dir_key_lo,
  input  logic [tlnt_pkg::HALF_W-1:0]   in_file_key_hi,
  input  logic [tlnt_pkg::HALF_W-1:0]   in_file_key_lo,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlnt_pkg::STATUS_W-1:0] out_status,
  output logic [tlnt_pkg::HALF_W-1:0]   out_entry_hi,
  output logic [tlnt_pkg::HALF_W-1:0]   out_entry_lo,
  output logic                          out_last
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DREAD  = 8'b0000_0010,
    S_DCMP   = 8'b0000_0100,
    S_FREAD  = 8'b0000_1000,
    S_FCMP   = 8'b0001_0000,
    S_MREAD  = 8'b0010_0000,
    S_MWRITE = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [tlnt_pkg::MODE_W-1:0]           mode_r, mode_nxt;
  logic [tlnt_pkg::NAME_BITS-1:0]        dkey_r, dkey_nxt;
  logic [tlnt_pkg::NAME_BITS-1:0]        fkey_r, fkey_nxt;
  logic [tlnt_pkg::DIR_CW-1:0]           idx_r, idx_nxt;
  logic [tlnt_pkg::DIR_AW-1:0]           dir_r, dir_nxt;
  logic [tlnt_pkg::FILE_CW-1:0]          fidx_r, fidx_nxt;
  logic [tlnt_pkg::DIR_CW-1:0]           dir_total_r, dir_total_nxt;
  logic [tlnt_pkg::FILE_CW-1:0]          file_totals_r [tlnt_pkg::MAX_DIRS];
  logic                                  ftot_we;
  logic [tlnt_pkg::DIR_AW-1:0]           ftot_addr;
  logic [tlnt_pkg::FILE_CW-1:0]          ftot_wdata;
  logic [tlnt_pkg::STATUS_W-1:0]         res_status_r, res_status_nxt;
  logic [tlnt_pkg::NAME_BITS-1:0]        res_entry_r, res_entry_nxt;
  logic                                  res_last_r, res_last_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [tlnt_pkg::STATUS_W-1:0]         out_status_r, out_status_nxt;
  logic [tlnt_pkg::KEY_W-1:0]            out_entry_r, out_entry_nxt;
  logic                                  out_last_r, out_last_nxt;

  logic                                  dram_we, dram_re;
  logic [tlnt_pkg::DIR_AW-1:0]           dram_waddr, dram_raddr;
  logic [tlnt_pkg::NAME_BITS-1:0]        dram_rdata;
  logic                                  fram_we, fram_re;
  logic [tlnt_pkg::FRAM_AW-1:0]          fram_waddr, fram_raddr;
  logic [tlnt_pkg::NAME_BITS-1:0]        fram_wdata, fram_rdata;

  logic [tlnt_pkg::KEY_W-1:0]            in_dkey_w, in_fkey_w;
  logic [tlnt_pkg::FILE_CW-1:0]          cnt_w;
  logic [tlnt_pkg::FILE_CW-1:0]          fidx_inc_w;
  logic [tlnt_pkg::FILE_CW-1:0]          cnt_dec_w;
  logic                                  out_free_w;

  tlnt_ram #(
    .WIDTH(tlnt_pkg::NAME_BITS),
    .DEPTH(tlnt_pkg::MAX_DIRS)
  ) u_dir_ram (
    .clk  (clk),
    .we   (dram_we),
    .waddr(dram_waddr),
    .wdata(dkey_r),
    .re   (dram_re),
    .raddr(dram_raddr),
    .rdata(dram_rdata)
  );

  tlnt_ram #(
    .WIDTH(tlnt_pkg::NAME_BITS),
    .DEPTH(tlnt_pkg::FRAM_DEPTH)
  ) u_file_ram (
    .clk  (clk),
    .we   (fram_we),
    .waddr(fram_waddr),
    .wdata(fram_wdata),
    .re   (fram_re),
    .raddr(fram_raddr),
    .rdata(fram_rdata)
  );

  assign in_dkey_w  = {in_dir_key_hi, in_dir_key_lo};
  assign in_fkey_w  = {in_file_key_hi, in_file_key_lo};
  assign cnt_w      = file_totals_r[dir_r];
  assign fidx_inc_w = tlnt_pkg::FILE_CW'(fidx_r + 1'b1);
  assign cnt_dec_w  = tlnt_pkg::FILE_CW'(cnt_w - 1'b1);
  assign out_free_w = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    dkey_nxt       = dkey_r;
    fkey_nxt       = fkey_r;
    idx_nxt        = idx_r;
    dir_nxt        = dir_r;
    fidx_nxt       = fidx_r;
    dir_total_nxt  = dir_total_r;
    ftot_we        = 1'b0;
    ftot_addr      = dir_r;
    ftot_wdata     = cnt_w;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    dram_we        = 1'b0;
    dram_waddr     = dir_total_r[tlnt_pkg::DIR_AW-1:0];
    dram_re        = 1'b0;
    dram_raddr     = idx_r[tlnt_pkg::DIR_AW-1:0];
    fram_we        = 1'b0;
    fram_waddr     = {dir_r, cnt_w[tlnt_pkg::FILE_AW-1:0]};
    fram_wdata     = fkey_r;
    fram_re        = 1'b0;
    fram_raddr     = {dir_r, fidx_r[tlnt_pkg::FILE_AW-1:0]};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt      = in_mode;
          dkey_nxt      = in_dkey_w[tlnt_pkg::KEY_W-1 -: tlnt_pkg::NAME_BITS];
          fkey_nxt      = in_fkey_w[tlnt_pkg::KEY_W-1 -: tlnt_pkg::NAME_BITS];
          idx_nxt       = '0;
          res_entry_nxt = '0;
          res_last_nxt  = 1'b1;
          if (in_mode inside {[tlnt_pkg::MODE_MKDIR:tlnt_pkg::MODE_LIST]}) begin
            state_nxt = S_DREAD;
          end else begin
            res_status_nxt = tlnt_pkg::ST_NOT_FOUND;
            state_nxt      = S_EMIT;
          end
        end
      end
      S_DREAD: begin
        if (idx_r == dir_total_r) begin
          state_nxt = S_EMIT;
          if (mode_r != tlnt_pkg::MODE_MKDIR) begin
            res_status_nxt = tlnt_pkg::ST_NO_DIR;
          end else if (dir_total_r == tlnt_pkg::DIR_CW'(tlnt_pkg::MAX_DIRS)) begin
            res_status_nxt = tlnt_pkg::ST_DIR_TABLE_FULL;
          end else begin
            dram_we        = 1'b1;
            ftot_we        = 1'b1;
            ftot_addr      = dir_total_r[tlnt_pkg::DIR_AW-1:0];
            ftot_wdata     = '0;
            dir_total_nxt  = tlnt_pkg::DIR_CW'(dir_total_r + 1'b1);
            res_status_nxt = tlnt_pkg::ST_DIR_MADE;
          end
        end else begin
          dram_re   = 1'b1;
          state_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        if (dram_rdata == dkey_r) begin
          if (mode_r == tlnt_pkg::MODE_MKDIR) begin
            res_status_nxt = tlnt_pkg::ST_DIR_EXISTS;
            state_nxt      = S_EMIT;
          end else begin
            dir_nxt   = idx_r[tlnt_pkg::DIR_AW-1:0];
            fidx_nxt  = '0;
            state_nxt = S_FREAD;
          end
        end else begin
          idx_nxt   = tlnt_pkg::DIR_CW'(idx_r + 1'b1);
          state_nxt = S_DREAD;
        end
      end
      S_FREAD: begin
        if (fidx_r == cnt_w) begin
          state_nxt = S_EMIT;
          case (mode_r)
            tlnt_pkg::MODE_MKFILE: begin
              if (cnt_w == tlnt_pkg::FILE_CW'(tlnt_pkg::FILES_PER_DIR)) begin
                res_status_nxt = tlnt_pkg::ST_DIR_FULL;
              end else begin
                fram_we        = 1'b1;
                ftot_we        = 1'b1;
                ftot_wdata     = tlnt_pkg::FILE_CW'(cnt_w + 1'b1);
                res_status_nxt = tlnt_pkg::ST_FILE_MADE;
              end
            end
            tlnt_pkg::MODE_LIST: begin
              res_status_nxt = tlnt_pkg::ST_DIR_EMPTY;
            end
            default: begin
              res_status_nxt = tlnt_pkg::ST_NOT_FOUND;
            end
          endcase
        end else begin
          fram_re   = 1'b1;
          state_nxt = S_FCMP;
        end
      end
      S_FCMP: begin
        if (mode_r == tlnt_pkg::MODE_LIST) begin
          res_status_nxt = tlnt_pkg::ST_LIST_ENTRY;
          res_entry_nxt  = fram_rdata;
          res_last_nxt   = (fidx_inc_w == cnt_w);
          state_nxt      = S_EMIT;
        end else if (fram_rdata == fkey_r) begin
          case (mode_r)
            tlnt_pkg::MODE_MKFILE: begin
              res_status_nxt = tlnt_pkg::ST_FILE_EXISTS;
              state_nxt      = S_EMIT;
            end
            tlnt_pkg::MODE_DELETE: begin
              state_nxt = S_MREAD;
            end
            default: begin
              res_status_nxt = tlnt_pkg::ST_FOUND;
              state_nxt      = S_EMIT;
            end
          endcase
        end else begin
          fidx_nxt  = fidx_inc_w;
          state_nxt = S_FREAD;
        end
      end
      S_MREAD: begin
        fram_re    = 1'b1;
        fram_raddr = {dir_r, cnt_dec_w[tlnt_pkg::FILE_AW-1:0]};
        state_nxt  = S_MWRITE;
      end
      S_MWRITE: begin
        fram_we        = 1'b1;
        fram_waddr     = {dir_r, fidx_r[tlnt_pkg::FILE_AW-1:0]};
        fram_wdata     = fram_rdata;
        ftot_we        = 1'b1;
        ftot_wdata     = cnt_dec_w;
        res_status_nxt = tlnt_pkg::ST_DELETED;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free_w) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = tlnt_pkg::KEY_W'(res_entry_r) << tlnt_pkg::PAD_BITS;
          out_last_nxt   = res_last_r;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            fidx_nxt  = fidx_inc_w;
            state_nxt = S_FREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_total_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < tlnt_pkg::MAX_DIRS; i++) begin
        file_totals_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      dir_total_r <= dir_total_nxt;
      out_valid_r <= out_valid_nxt;
      if (ftot_we) begin
        file_totals_r[ftot_addr] <= ftot_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    dkey_r       <= dkey_nxt;
    fkey_r       <= fkey_nxt;
    idx_r        <= idx_nxt;
    dir_r        <= dir_nxt;
    fidx_r       <= fidx_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_entry_hi = out_entry_r[tlnt_pkg::KEY_W-1 -: tlnt_pkg::HALF_W];
  assign out_entry_lo = out_entry_r[tlnt_pkg::HALF_W-1:0];
  assign out_last     = out_last_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for two_level_name_table_top: directed and random commands checked
// word by word against a predictor of the directory and file tables.
// Depends on tlnt_pkg and the top level RTL only.
module tb_top;
  import tlnt_pkg::*;

  localparam int DIR_POOL  = 12;
  localparam int FILE_POOL = 12;
  localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} << PAD_BITS;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HALF_W-1:0]   entry_hi;
    logic [HALF_W-1:0]   entry_lo;
    logic                last;
  } table_reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [HALF_W-1:0]   in_dir_key_hi;
  logic [HALF_W-1:0]   in_dir_key_lo;
  logic [HALF_W-1:0]   in_file_key_hi;
  logic [HALF_W-1:0]   in_file_key_lo;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [HALF_W-1:0]   out_entry_hi;
  logic [HALF_W-1:0]   out_entry_lo;
  logic                out_last;

  table_reply_t     expected_replies[$];
  logic [KEY_W-1:0] dir_names[MAX_DIRS];
  int               dir_count;
  logic [KEY_W-1:0] file_names[MAX_DIRS][FILES_PER_DIR];
  int               file_count[MAX_DIRS];
  logic [KEY_W-1:0] dir_pool[DIR_POOL];
  logic [KEY_W-1:0] file_pool[FILE_POOL];

  int errors;
  bit send_gaps;
  int stall_pct;
  int hold_left;

  two_level_name_table_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_dir_key_hi(in_dir_key_hi),
    .in_dir_key_lo(in_dir_key_lo),
    .in_file_key_hi(in_file_key_hi),
    .in_file_key_lo(in_file_key_lo),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_hi(out_entry_hi),
    .out_entry_lo(out_entry_lo),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("two_level_name_table_top test failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic int find_dir(input logic [KEY_W-1:0] key);
    for (int i = 0; i < dir_count; i++) begin
      if (dir_names[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int find_file(input int d, input logic [KEY_W-1:0] key);
    for (int i = 0; i < file_count[d]; i++) begin
      if (file_names[d][i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void push_reply(input logic [STATUS_W-1:0] status,
                                     input logic [KEY_W-1:0] entry, input logic last);
    table_reply_t r;
    r.status   = status;
    r.entry_hi = entry[KEY_W-1:HALF_W];
    r.entry_lo = entry[HALF_W-1:0];
    r.last     = last;
    expected_replies.push_back(r);
  endfunction

  function automatic void predict_reply(input logic [MODE_W-1:0] mode,
                                        input logic [KEY_W-1:0] dkey_in,
                                        input logic [KEY_W-1:0] fkey_in);
    logic [KEY_W-1:0] dkey;
    logic [KEY_W-1:0] fkey;
    int d;
    int f;
    int n;
    dkey = dkey_in & NAME_MASK;
    fkey = fkey_in & NAME_MASK;
    if (mode == MODE_MKDIR) begin
      if (find_dir(dkey) >= 0) begin
        push_reply(ST_DIR_EXISTS, '0, 1'b1);
      end else if (dir_count >= MAX_DIRS) begin
        push_reply(ST_DIR_TABLE_FULL, '0, 1'b1);
      end else begin
        dir_names[dir_count] = dkey;
        file_count[dir_count] = 0;
        dir_count++;
        push_reply(ST_DIR_MADE, '0, 1'b1);
      end
      return;
    end
    if (mode > MODE_LIST) begin
      push_reply(ST_NOT_FOUND, '0, 1'b1);
      return;
    end
    d = find_dir(dkey);
    if (d < 0) begin
      push_reply(ST_NO_DIR, '0, 1'b1);
      return;
    end
    n = file_count[d];
    case (mode)
      MODE_MKFILE: begin
        if (find_file(d, fkey) >= 0) begin
          push_reply(ST_FILE_EXISTS, '0, 1'b1);
        end else if (n >= FILES_PER_DIR) begin
          push_reply(ST_DIR_FULL, '0, 1'b1);
        end else begin
          file_names[d][n] = fkey;
          file_count[d] = n + 1;
          push_reply(ST_FILE_MADE, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        f = find_file(d, fkey);
        if (f < 0) begin
          push_reply(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          file_names[d][f] = file_names[d][n-1];
          file_count[d] = n - 1;
          push_reply(ST_DELETED, '0, 1'b1);
        end
      end
      MODE_SEARCH: begin
        push_reply((find_file(d, fkey) >= 0) ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
      end
      default: begin
        if (n == 0) begin
          push_reply(ST_DIR_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_reply(ST_LIST_ENTRY, file_names[d][i], i == n - 1);
          end
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_cmd(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] dkey,
                           input logic [KEY_W-1:0] fkey);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_dir_key_hi  <= dkey[KEY_W-1:HALF_W];
    in_dir_key_lo  <= dkey[HALF_W-1:0];
    in_file_key_hi <= fkey[KEY_W-1:HALF_W];
    in_file_key_lo <= fkey[HALF_W-1:0];
    do @(posedge clk); while (in_stall);
    predict_reply(mode, dkey, fkey);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [HALF_W-1:0] want,
                             input logic [HALF_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    table_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual status %0d entry %h%h last %b",
                 $time, out_status, out_entry_hi, out_entry_lo, out_last);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", HALF_W'(want.status), HALF_W'(out_status));
        check_field("entry_hi", want.entry_hi, out_entry_hi);
        check_field("entry_lo", want.entry_lo, out_entry_lo);
        check_field("last", HALF_W'(want.last), HALF_W'(out_last));
      end
    end
  end

  initial begin : out_stall_gen
    int burst;
    int r;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stall_pct == 0) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) burst = $urandom_range(10, 40);
        out_stall <= (r < stall_pct);
      end
    end
  end

  task automatic test_unknown_dir();
    issue_cmd(MODE_MKFILE, dir_pool[0], file_pool[0]);
    issue_cmd(MODE_DELETE, dir_pool[0], file_pool[0]);
    issue_cmd(MODE_SEARCH, dir_pool[0], file_pool[1]);
    issue_cmd(MODE_LIST, dir_pool[1], random_key());
    for (int m = int'(MODE_LIST) + 1; m < (1 << MODE_W); m++) begin
      issue_cmd(MODE_W'(m), random_key(), random_key());
    end
  endtask

  task automatic test_extreme_keys();
    issue_cmd(MODE_MKDIR, dir_pool[0], random_key());
    issue_cmd(MODE_MKDIR, dir_pool[1], random_key());
    issue_cmd(MODE_MKDIR, dir_pool[0], random_key());
    issue_cmd(MODE_LIST, dir_pool[0], random_key());
    issue_cmd(MODE_MKFILE, dir_pool[0], file_pool[0]);
    issue_cmd(MODE_MKFILE, dir_pool[0], file_pool[1]);
    issue_cmd(MODE_MKFILE, dir_pool[0], file_pool[0]);
    issue_cmd(MODE_SEARCH, dir_pool[0], file_pool[1]);
    issue_cmd(MODE_SEARCH, dir_pool[1], file_pool[1]);
    issue_cmd(MODE_DELETE, dir_pool[1], file_pool[0]);
    issue_cmd(MODE_DELETE, dir_pool[0], file_pool[0]);
    issue_cmd(MODE_LIST, dir_pool[0], random_key());
  endtask

  task automatic test_full_directory();
    for (int i = 2; i < 2 + FILES_PER_DIR; i++) begin
      issue_cmd(MODE_MKFILE, dir_pool[1], file_pool[i]);
    end
    issue_cmd(MODE_MKFILE, dir_pool[1], file_pool[2 + FILES_PER_DIR]);
    issue_cmd(MODE_MKFILE, dir_pool[1], file_pool[2]);
    issue_cmd(MODE_LIST, dir_pool[1], random_key());
    issue_cmd(MODE_DELETE, dir_pool[1], file_pool[4]);
    issue_cmd(MODE_LIST, dir_pool[1], random_key());
  endtask

  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    @(posedge clk);
    hold_left = 200;
    issue_cmd(MODE_LIST, dir_pool[1], random_key());
    issue_cmd(MODE_SEARCH, dir_pool[1], file_pool[3]);
    issue_cmd(MODE_LIST, dir_pool[0], random_key());
    issue_cmd(MODE_LIST, dir_pool[1], random_key());
    issue_cmd(MODE_MKDIR, dir_pool[2], random_key());
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0] dkey;
    logic [KEY_W-1:0] fkey;
    for (int i = 0; i < count; i++) begin
      if (i % 75 == 0) begin
        case (i / 75)
          0: begin send_gaps = 1'b0; stall_pct = 0; end
          1: begin send_gaps = 1'b1; stall_pct = 25; end
          2: begin send_gaps = 1'b0; stall_pct = 60; end
          default: begin send_gaps = 1'b1; stall_pct = 10; end
        endcase
      end
      if ($urandom_range(0, 39) == 0) pause_until_drained();
      dkey = ($urandom_range(0, 9) != 0) ? dir_pool[$urandom_range(0, DIR_POOL - 1)]
                                         : random_key();
      fkey = ($urandom_range(0, 9) != 0) ? file_pool[$urandom_range(0, FILE_POOL - 1)]
                                         : random_key();
      r = $urandom_range(0, 99);
      if (r < 8) mode = MODE_MKDIR;
      else if (r < 45) mode = MODE_MKFILE;
      else if (r < 62) mode = MODE_DELETE;
      else if (r < 77) mode = MODE_SEARCH;
      else if (r < 90) mode = MODE_LIST;
      else if (r < 94) mode = MODE_W'($urandom_range(int'(MODE_LIST) + 1, (1 << MODE_W) - 1));
      else begin
        mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
        dkey = random_key();
      end
      if (mode == MODE_MKDIR || mode == MODE_LIST) fkey = random_key();
      issue_cmd(mode, dkey, fkey);
    end
  endtask

  task automatic test_dir_table_full();
    send_gaps = 1'b1;
    stall_pct = 15;
    while (dir_count < MAX_DIRS) issue_cmd(MODE_MKDIR, random_key(), random_key());
    issue_cmd(MODE_MKDIR, random_key(), random_key());
    issue_cmd(MODE_MKDIR, dir_names[0], random_key());
    issue_cmd(MODE_MKFILE, dir_names[MAX_DIRS-1], random_key());
    issue_cmd(MODE_LIST, dir_names[MAX_DIRS-1], random_key());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = '0;
    in_dir_key_hi  = '0;
    in_dir_key_lo  = '0;
    in_file_key_hi = '0;
    in_file_key_lo = '0;
    errors         = 0;
    send_gaps      = 1'b0;
    stall_pct      = 0;
    hold_left      = 0;
    dir_count      = 0;
    for (int i = 0; i < MAX_DIRS; i++) file_count[i] = 0;
    for (int i = 0; i < DIR_POOL; i++) dir_pool[i] = random_key();
    for (int i = 0; i < FILE_POOL; i++) file_pool[i] = random_key();
    dir_pool[0]  = '0;
    dir_pool[1]  = '1;
    file_pool[0] = '0;
    file_pool[1] = '1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unknown_dir();
    test_extreme_keys();
    send_gaps = 1'b1;
    stall_pct = 20;
    test_full_directory();
    test_output_backpressure();
    test_random_traffic(250);
    test_dir_table_full();

    pause_until_drained();
    repeat (60) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, expected_replies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("two_level_name_table_top test passed");
    end else begin
      $display("two_level_name_table_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tlnt_pkg.sv
hw/rtl/tlnt_ram.sv
hw/rtl/two_level_name_table_top.sv
test/tb_top.sv
